// ===== rtl/complex_arithmetic_unit_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Check that cons holds in the same cycle as ante, except during reset.
`define CAU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds in the cycle after ante, with reset cycles included.
`define CAU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/cau_pkg.sv =====
package cau_pkg;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_SUB,
    CMD_MUL,
    CMD_DIV
  } cmd_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
    logic dz;
    logic neg_re;
    logic neg_im;
  } cau_ctl_t;

endpackage

// ===== rtl/cau_front.sv =====
module cau_front #(
  parameter int W = 16,
  parameter int F = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  logic [1:0]             cmd,
  input  logic [W-1:0]           a_re,
  input  logic [W-1:0]           a_im,
  input  logic [W-1:0]           b_re,
  input  logic [W-1:0]           b_im,
  output cau_pkg::cau_ctl_t      ctl,
  output logic [2*W+F-1:0]       num_re,
  output logic [2*W+F-1:0]       num_im,
  output logic [2*W-1:0]         den
);
  import cau_pkg::*;

  localparam int MW = 2*W+F;

  // operand register
  logic            va;
  cmd_t            cmd_a;
  logic signed [W-1:0] a, b, c, d;

  // product register
  logic            vb;
  cmd_t            cmd_b;
  logic            dz_b;
  logic signed [2*W-1:0] ac, bd, ad, bc, cc, dd;
  logic signed [W:0]     s_re, s_im;

  logic signed [2*W:0] p_re, p_im;
  logic [2*W:0]        m_re, m_im;
  logic [MW-1:0]       n_re_next, n_im_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (adv) begin
      va <= in_valid;
      vb <= va;
      ctl.valid <= vb;
    end
    if (adv) begin
      cmd_a <= cmd_t'(cmd);
      a <= a_re;
      b <= a_im;
      c <= b_re;
      d <= b_im;

      cmd_b <= cmd_a;
      dz_b  <= (c == '0) && (d == '0);
      ac <= a * c;
      bd <= b * d;
      ad <= a * d;
      bc <= b * c;
      cc <= c * c;
      dd <= d * d;
      if (cmd_a == CMD_SUB) begin
        s_re <= {a[W-1], a} - {c[W-1], c};
        s_im <= {b[W-1], b} - {d[W-1], d};
      end else begin
        s_re <= {a[W-1], a} + {c[W-1], c};
        s_im <= {b[W-1], b} + {d[W-1], d};
      end

      ctl.cmd    <= cmd_b;
      ctl.dz     <= dz_b;
      ctl.neg_re <= p_re[2*W];
      ctl.neg_im <= p_im[2*W];
      num_re <= n_re_next;
      num_im <= n_im_next;
      den    <= $unsigned(cc) + $unsigned(dd);
    end
  end

  always_comb begin
    case (cmd_b)
      CMD_MUL: begin
        p_re = {ac[2*W-1], ac} - {bd[2*W-1], bd};
        p_im = {ad[2*W-1], ad} + {bc[2*W-1], bc};
      end
      CMD_DIV: begin
        p_re = {ac[2*W-1], ac} + {bd[2*W-1], bd};
        p_im = {bc[2*W-1], bc} - {ad[2*W-1], ad};
      end
      default: begin
        p_re = (2*W+1)'(s_re);
        p_im = (2*W+1)'(s_im);
      end
    endcase
    m_re = p_re[2*W] ? $unsigned(-p_re) : $unsigned(p_re);
    m_im = p_im[2*W] ? $unsigned(-p_im) : $unsigned(p_im);
    // magnitudes never exceed 2^(2W-1), so the top bit drops cleanly
    case (cmd_b)
      CMD_MUL: begin
        n_re_next = MW'(m_re[2*W-1:0] >> F);
        n_im_next = MW'(m_im[2*W-1:0] >> F);
      end
      CMD_DIV: begin
        n_re_next = MW'(m_re[2*W-1:0]) << F;
        n_im_next = MW'(m_im[2*W-1:0]) << F;
      end
      default: begin
        n_re_next = MW'(m_re[2*W-1:0]);
        n_im_next = MW'(m_im[2*W-1:0]);
      end
    endcase
  end

endmodule

// ===== rtl/cau_cell.sv =====
module cau_cell #(
  parameter int W     = 16,
  parameter int F     = 8,
  parameter int SHIFT = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  cau_pkg::cau_ctl_t      src_ctl,
  input  logic [2*W+F-1:0]       src_num_re,
  input  logic [2*W+F-1:0]       src_num_im,
  input  logic [W:0]             src_q_re,
  input  logic [W:0]             src_q_im,
  input  logic [2*W-1:0]         src_den,
  output cau_pkg::cau_ctl_t      dst_ctl,
  output logic [2*W+F-1:0]       dst_num_re,
  output logic [2*W+F-1:0]       dst_num_im,
  output logic [W:0]             dst_q_re,
  output logic [W:0]             dst_q_im,
  output logic [2*W-1:0]         dst_den
);
  import cau_pkg::*;

  localparam int MW = 2*W+F;
  localparam int NW = 3*W+F;

  logic [NW-1:0] dsh;
  logic          div, ge_re, ge_im;
  logic [MW-1:0] num_re_next, num_im_next;

  always_comb begin
    dsh   = NW'(src_den) << SHIFT;
    div   = (src_ctl.cmd == CMD_DIV);
    ge_re = div && (NW'(src_num_re) >= dsh);
    ge_im = div && (NW'(src_num_im) >= dsh);
    num_re_next = ge_re ? MW'(NW'(src_num_re) - dsh) : src_num_re;
    num_im_next = ge_im ? MW'(NW'(src_num_im) - dsh) : src_num_im;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_ctl.valid <= 1'b0;
    end else if (adv) begin
      dst_ctl.valid <= src_ctl.valid;
    end
    if (adv) begin
      dst_ctl.cmd    <= src_ctl.cmd;
      dst_ctl.dz     <= src_ctl.dz;
      dst_ctl.neg_re <= src_ctl.neg_re;
      dst_ctl.neg_im <= src_ctl.neg_im;
      dst_num_re <= num_re_next;
      dst_num_im <= num_im_next;
      dst_q_re   <= {src_q_re[W-1:0], ge_re};
      dst_q_im   <= {src_q_im[W-1:0], ge_im};
      dst_den    <= src_den;
    end
  end

endmodule

// ===== rtl/complex_arithmetic_unit.sv =====
// Pipeline: an accepted request passes through the operand, product and
// combine registers, one divider cell per quotient bit (DATA_WIDTH + 1 cells),
// and the output register.
// Throughput: one request per cycle; the whole pipe holds while the result waits.
// Reset (synchronous) clears every stage valid bit; data registers are not reset.
`include "complex_arithmetic_unit_macros.svh"

module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            cmd,
  input  logic [DATA_WIDTH-1:0] a_re,
  input  logic [DATA_WIDTH-1:0] a_im,
  input  logic [DATA_WIDTH-1:0] b_re,
  input  logic [DATA_WIDTH-1:0] b_im,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] res_re,
  output logic [DATA_WIDTH-1:0] res_im,
  output logic [1:0]            status
);
  import cau_pkg::*;

  localparam int W  = DATA_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int MW = 2*W+F;
  localparam int NC = W+1;
  localparam logic [MW-1:0] LIM_NEG = MW'(1) << (W-1);
  localparam logic [MW-1:0] LIM_POS = LIM_NEG - MW'(1);

  logic adv;

  cau_ctl_t       ctl   [NC+1];
  logic [MW-1:0]  num_re[NC+1];
  logic [MW-1:0]  num_im[NC+1];
  logic [W:0]     q_re  [NC+1];
  logic [W:0]     q_im  [NC+1];
  logic [2*W-1:0] den   [NC+1];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;
  assign q_re[0]  = '0;
  assign q_im[0]  = '0;

  cau_front #(.W(W), .F(F)) u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (in_valid),
    .cmd      (cmd),
    .a_re     (a_re),
    .a_im     (a_im),
    .b_re     (b_re),
    .b_im     (b_im),
    .ctl      (ctl[0]),
    .num_re   (num_re[0]),
    .num_im   (num_im[0]),
    .den      (den[0])
  );

  // one quotient bit per cell, most significant first
  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell #(.W(W), .F(F), .SHIFT(W-i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .adv        (adv),
      .src_ctl    (ctl[i]),
      .src_num_re (num_re[i]),
      .src_num_im (num_im[i]),
      .src_q_re   (q_re[i]),
      .src_q_im   (q_im[i]),
      .src_den    (den[i]),
      .dst_ctl    (ctl[i+1]),
      .dst_num_re (num_re[i+1]),
      .dst_num_im (num_im[i+1]),
      .dst_q_re   (q_re[i+1]),
      .dst_q_im   (q_im[i+1]),
      .dst_den    (den[i+1])
    );
  end

  cau_ctl_t      fin;
  logic [MW-1:0] mag_re, mag_im;
  logic          sat_re, sat_im;
  logic [W-1:0]  re_next, im_next;
  logic [1:0]    status_next;

  always_comb begin
    fin    = ctl[NC];
    mag_re = (fin.cmd == CMD_DIV) ? MW'(q_re[NC]) : num_re[NC];
    mag_im = (fin.cmd == CMD_DIV) ? MW'(q_im[NC]) : num_im[NC];
    if (fin.neg_re) begin
      sat_re  = mag_re > LIM_NEG;
      re_next = sat_re ? W'(-LIM_NEG) : W'(-mag_re);
    end else begin
      sat_re  = mag_re > LIM_POS;
      re_next = sat_re ? W'(LIM_POS) : W'(mag_re);
    end
    if (fin.neg_im) begin
      sat_im  = mag_im > LIM_NEG;
      im_next = sat_im ? W'(-LIM_NEG) : W'(-mag_im);
    end else begin
      sat_im  = mag_im > LIM_POS;
      im_next = sat_im ? W'(LIM_POS) : W'(mag_im);
    end
    status_next = (sat_re || sat_im) ? ST_SAT : ST_OK;
    // zero divisor: drop the quotient
    if (fin.cmd == CMD_DIV && fin.dz) begin
      re_next     = '0;
      im_next     = '0;
      status_next = ST_DZ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= fin.valid;
    end
    if (adv) begin
      res_re <= re_next;
      res_im <= im_next;
      status <= status_next;
    end
  end

  `CAU_ASSERT_IMPL(a_dz_zero, out_valid && status == ST_DZ, res_re == '0 && res_im == '0)
  `CAU_ASSERT_IMPL(a_status_code, out_valid,
                   status == ST_OK || status == ST_SAT || status == ST_DZ)
  `CAU_ASSERT_NEXT(a_reset_idle, rst, !out_valid && !ctl[NC].valid)

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import cau_pkg::*;

  localparam int DW = 16;
  localparam int FB = 8;
  localparam int LATENCY = DW + 5;

  typedef struct packed {
    logic signed [DW-1:0] re;
    logic signed [DW-1:0] im;
    logic [1:0]           st;
  } cplx_res_t;

  typedef struct packed {
    cmd_t                 op;
    logic signed [DW-1:0] ar;
    logic signed [DW-1:0] ai;
    logic signed [DW-1:0] br;
    logic signed [DW-1:0] bi;
    logic                 has_exp;
    cplx_res_t            exp_res;
  } stim_row_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [1:0] cmd;
  logic [DW-1:0] a_re, a_im, b_re, b_im;
  logic out_valid;
  logic out_ready;
  logic [DW-1:0] res_re, res_im;
  logic [1:0] status;

  complex_arithmetic_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_re(res_re), .res_im(res_im), .status(status)
  );

  cplx_res_t pending_results[$];
  int errors = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_sat = 0;
  int n_dz = 0;
  int send_idle_pct = 13;
  int recv_idle_pct = 74;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

  // Clamp a signed value to the output range, flag saturation.
  function automatic logic signed [DW-1:0] clamp(input longint v, inout logic sat);
    longint hi, lo;
    hi = (64'sd1 <<< (DW - 1)) - 1;
    lo = -(64'sd1 <<< (DW - 1));
    if (v > hi) begin
      sat = 1'b1;
      return hi[DW-1:0];
    end
    if (v < lo) begin
      sat = 1'b1;
      return lo[DW-1:0];
    end
    return v[DW-1:0];
  endfunction

  // Truncating fixed point quotient n * 2^FB / den, exact in 64 bits.
  function automatic longint fx_quot(input longint n, input longint den);
    longint mag, q, r;
    mag = (n < 0) ? -n : n;
    q = mag / den;
    r = mag % den;
    q = (q << FB) + ((r << FB) / den);
    return (n < 0) ? -q : q;
  endfunction

  function automatic cplx_res_t complex_op(input cmd_t op, input logic signed [DW-1:0] ar,
      input logic signed [DW-1:0] ai, input logic signed [DW-1:0] br,
      input logic signed [DW-1:0] bi);
    longint a, b, c, d, pr, pi, den, t;
    logic sat;
    cplx_res_t r;
    a = ar; b = ai; c = br; d = bi;
    sat = 1'b0;
    case (op)
      CMD_ADD: begin
        pr = a + c; pi = b + d;
      end
      CMD_SUB: begin
        pr = a - c; pi = b - d;
      end
      CMD_MUL: begin
        t = a * c - b * d;
        pr = (t < 0) ? -((-t) >>> FB) : (t >>> FB);
        t = a * d + b * c;
        pi = (t < 0) ? -((-t) >>> FB) : (t >>> FB);
      end
      default: begin
        if (c == 0 && d == 0) begin
          r.re = '0; r.im = '0; r.st = ST_DZ;
          return r;
        end
        den = c * c + d * d;
        pr = fx_quot(a * c + b * d, den);
        pi = fx_quot(b * c - a * d, den);
      end
    endcase
    r.re = clamp(pr, sat);
    r.im = clamp(pi, sat);
    r.st = sat ? ST_SAT : ST_OK;
    return r;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %0s at result %0d: got %0d expected %0d", what, n_checked, got, want);
  endtask

  // Result side: random stall, check every accepted result.
  initial begin
    cplx_res_t e;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report("unexpected result", res_re, 0);
        end else begin
          e = pending_results.pop_front();
          if (res_re !== e.re) report("res_re", $signed(res_re), e.re);
          if (res_im !== e.im) report("res_im", $signed(res_im), e.im);
          if (status !== e.st) report("status", status, e.st);
          if (e.st == ST_SAT) n_sat++;
          if (e.st == ST_DZ) n_dz++;
        end
        n_checked++;
      end
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Drive one request, hold until accepted, queue its expected result.
  task automatic send(input cmd_t op, input logic [DW-1:0] ar, input logic [DW-1:0] ai,
      input logic [DW-1:0] br, input logic [DW-1:0] bi, input logic has_exp,
      input cplx_res_t want);
    cplx_res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op; a_re <= ar; a_im <= ai; b_re <= br; b_im <= bi;
    p = complex_op(op, ar, ai, br, bi);
    if (has_exp && p !== want)
      report("predictor vs table", {p.re, p.im}, {want.re, want.im});
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(p);
    n_sent++;
  endtask

  function automatic logic [DW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($signed($urandom_range(1024)) - 512);
      default: return DW'($urandom);
    endcase
  endfunction

  stim_row_t dir_table[] = '{
    '{CMD_ADD, 16'h0100, 16'h0200, 16'h0300, 16'h0400, 1'b1, '{16'h0400, 16'h0600, ST_OK}},
    '{CMD_ADD, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1'b1, '{16'h7fff, 16'h7fff, ST_SAT}},
    '{CMD_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 1'b1, '{16'h8000, 16'h8000, ST_SAT}},
    '{CMD_SUB, 16'h0500, 16'h0100, 16'h0200, 16'h0300, 1'b1, '{16'h0300, 16'hfe00, ST_OK}},
    '{CMD_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1'b1, '{16'h8000, 16'h7fff, ST_SAT}},
    '{CMD_SUB, 16'h0000, 16'h0000, 16'h8000, 16'h8000, 1'b1, '{16'h7fff, 16'h7fff, ST_SAT}},
    '{CMD_MUL, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1, '{16'h0100, 16'h0000, ST_OK}},
    '{CMD_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
    '{CMD_MUL, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000, 1'b0, '0},
    '{CMD_MUL, 16'hffff, 16'h0001, 16'h0001, 16'h0001, 1'b0, '0},
    '{CMD_MUL, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_OK}},
    '{CMD_DIV, 16'h0100, 16'h0000, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_DZ}},
    '{CMD_DIV, 16'h8000, 16'h7fff, 16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, ST_DZ}},
    '{CMD_DIV, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 1'b1, '{16'h0100, 16'h0000, ST_OK}},
    '{CMD_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000, 1'b0, '0},
    '{CMD_DIV, 16'h8000, 16'h8000, 16'h0001, 16'h0001, 1'b0, '0},
    '{CMD_DIV, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 1'b0, '0},
    '{CMD_DIV, 16'hff00, 16'h0300, 16'h0200, 16'hfd00, 1'b0, '0}
  };

  initial begin
    int guard;
    rst <= 1'b1;
    in_valid <= 1'b0;
    cmd <= '0; a_re <= '0; a_im <= '0; b_re <= '0; b_im <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_table[i])
      send(dir_table[i].op, dir_table[i].ar, dir_table[i].ai, dir_table[i].br,
           dir_table[i].bi, dir_table[i].has_exp, dir_table[i].exp_res);
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 13 : (ph == 1) ? 74 : 0;
      recv_idle_pct = (ph == 0) ? 74 : (ph == 1) ? 13 : 0;
      for (int k = 0; k < 630; k++) begin
        logic [DW-1:0] br, bi;
        br = rand_operand();
        bi = rand_operand();
        // zero operand b on some requests, so some divides see a zero divisor
        if ($urandom_range(19) == 0) begin
          br = '0; bi = '0;
        end
        send(cmd_t'($urandom_range(3)), rand_operand(), rand_operand(), br, bi, 1'b0, '0);
      end
    end
    in_valid <= 1'b0;
    guard = 0;
    while (pending_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 4) @(posedge clk);
    $display("sent %0d requests, checked %0d results (%0d saturated, %0d divide by zero)",
             n_sent, n_checked, n_sat, n_dz);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== complex_arithmetic_unit.f =====
+incdir+rtl
rtl/cau_pkg.sv
rtl/cau_front.sv
rtl/cau_cell.sv
rtl/complex_arithmetic_unit.sv
test/tb_top.sv
